// File: rtl/template_input_mask_formatter_top_defines.svh
// Assertion macros shared by the template input mask formatter.
`ifndef TEMPLATE_INPUT_MASK_FORMATTER_TOP_DEFINES_SVH
`define TEMPLATE_INPUT_MASK_FORMATTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TIMF_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define TIMF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TIMF_ASSERT(lbl, expr, msg)
`define TIMF_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: rtl/timf_pkg.sv
// Shared constants, types and codes of the template input mask formatter.
package timf_pkg;

    localparam int TEMPLATE_CHARS = 56;
    localparam int TEMPLATE_WORDS = (TEMPLATE_CHARS + 7) / 8;
    localparam int NUM_REGS       = TEMPLATE_WORDS + 1;
    localparam int REG_IDX_W      = $clog2(NUM_REGS);
    localparam int ADDR_W         = REG_IDX_W + 3;
    localparam int DATA_W         = 64;
    localparam int POS_W          = $clog2(TEMPLATE_CHARS + 1);
    localparam int BYTE_IDX_W     = $clog2(TEMPLATE_CHARS);
    localparam int CNT_W          = 16;

    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(TEMPLATE_WORDS);
    localparam logic [CNT_W-1:0]     CAPACITY_RESET = 16'd64;

    localparam logic [7:0] CH_X     = "X";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_A_UP  = "A";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_A_LOW = "a";
    localparam logic [7:0] CH_Z_LOW = "z";
    localparam logic [7:0] CH_Z_UP  = "Z";

    typedef logic [7:0]        char_t;
    typedef logic [DATA_W-1:0] cfg_word_t;

    typedef struct packed {
        logic  cmd;
        char_t in_char;
    } in_item_t;

    typedef struct packed {
        char_t out_char;
        logic  last;
    } out_item_t;

    typedef struct packed {
        logic [TEMPLATE_CHARS*8-1:0] tpl;
        logic [CNT_W-1:0]            capacity;
    } cfg_t;

    typedef enum logic [1:0] {
        EMIT_CHAR,
        EMIT_TPL,
        EMIT_TERM
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        emit_sel_t sel;
        logic      advance;
        logic      clear;
    } dp_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic in_tpl;
        logic cap_ok;
        logic t_is_x;
        logic t_is_nine;
        logic t_is_a;
        logic ch_digit;
        logic ch_alpha;
        logic ch_eq_t;
        logic slot_free;
    } dp_stat_t;

endpackage

// File: rtl/timf_cfg_regs.sv
// APB-style register file holding the template words and the output capacity.
module timf_cfg_regs
    import timf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  cfg_word_t         pwdata,
    output cfg_word_t         prdata,
    output cfg_t              cfg
);

    cfg_word_t              tpl_reg [TEMPLATE_WORDS];
    logic [CNT_W-1:0]       capacity_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < TEMPLATE_WORDS; w++)
            begin
                tpl_reg[w] <= '0;
            end
            capacity_reg <= CAPACITY_RESET;
        end
        else if (wr_en)
        begin
            for (int w = 0; w < TEMPLATE_WORDS; w++)
            begin
                if (reg_idx == REG_IDX_W'(w))
                begin
                    tpl_reg[w] <= pwdata;
                end
            end
            if (reg_idx == REG_CAPACITY)
            begin
                capacity_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int w = 0; w < TEMPLATE_WORDS; w++)
        begin
            if (reg_idx == REG_IDX_W'(w))
            begin
                prdata = tpl_reg[w];
            end
        end
        if (reg_idx == REG_CAPACITY)
        begin
            prdata = DATA_W'(capacity_reg);
        end
    end

    // Template character k sits in byte k mod 8 of word k / 8.
    for (genvar k = 0; k < TEMPLATE_CHARS; k++)
    begin : g_flat
        assign cfg.tpl[k*8 +: 8] = tpl_reg[k / 8][(k % 8) * 8 +: 8];
    end

    assign cfg.capacity = capacity_reg;

endmodule

// File: rtl/timf_datapath.sv
// Datapath: template position, output count, latched character and result register.
module timf_datapath
    import timf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  cfg_t      cfg,
    input  dp_cmd_t   dp_cmd,
    output dp_stat_t  dp_stat,
    input  logic      res_stall,
    output logic      res_valid,
    output out_item_t res
);

    logic [POS_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        cnt_reg;
    char_t                   ch_reg;
    logic                    res_valid_reg;
    out_item_t               res_reg;
    out_item_t               res_next;
    char_t                   tpl_byte [TEMPLATE_CHARS];
    logic [TEMPLATE_CHARS-1:0] nonzero;
    logic [TEMPLATE_CHARS-1:0] upto_pos;
    logic                    pos_in_range;
    char_t                   tchar;

    for (genvar k = 0; k < TEMPLATE_CHARS; k++)
    begin : g_bytes
        assign tpl_byte[k] = cfg.tpl[k*8 +: 8];
        assign nonzero[k]  = |cfg.tpl[k*8 +: 8];
        assign upto_pos[k] = (POS_W'(k) <= pos_reg);
    end

    assign pos_in_range = (pos_reg < POS_W'(TEMPLATE_CHARS));
    assign tchar        = pos_in_range ? tpl_byte[pos_reg[BYTE_IDX_W-1:0]] : '0;

    // The position lies inside the template when no zero byte stands at or before it.
    always_comb
    begin
        dp_stat.in_zero   = (item.in_char == '0);
        dp_stat.in_tpl    = pos_in_range && (&(nonzero | ~upto_pos));
        dp_stat.cap_ok    = (cfg.capacity != '0) && (cnt_reg < (cfg.capacity - CNT_W'(1)));
        dp_stat.t_is_x    = (tchar == CH_X);
        dp_stat.t_is_nine = (tchar == CH_NINE);
        dp_stat.t_is_a    = (tchar == CH_A_UP);
        dp_stat.ch_digit  = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
        dp_stat.ch_alpha  = ((ch_reg >= CH_A_LOW) && (ch_reg <= CH_Z_LOW)) ||
                            ((ch_reg >= CH_A_UP) && (ch_reg <= CH_Z_UP));
        dp_stat.ch_eq_t   = (ch_reg == tchar);
        dp_stat.slot_free = !res_valid_reg || !res_stall;
    end

    always_comb
    begin
        case (dp_cmd.sel)
            EMIT_CHAR:
            begin
                res_next = '{out_char: ch_reg, last: 1'b0};
            end
            EMIT_TPL:
            begin
                res_next = '{out_char: tchar, last: 1'b0};
            end
            default:
            begin
                res_next = '{out_char: '0, last: 1'b1};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.clear)
            begin
                pos_reg <= '0;
                cnt_reg <= '0;
            end
            else if (dp_cmd.advance)
            begin
                pos_reg <= pos_reg + POS_W'(1);
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (dp_cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            ch_reg <= item.in_char;
        end
        if (dp_cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/timf_ctrl.sv
// Controller: walks the template for each request, one position per cycle unless stalled.
module timf_ctrl
    import timf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     item_cmd,
    output logic     item_stall,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  dp_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAR,
        ST_END
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   can_step;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign can_step   = dp_stat.in_tpl && dp_stat.cap_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        dp_cmd         = '0;
        dp_cmd.sel     = EMIT_TPL;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dp_cmd.load = 1'b1;
                    if (item_cmd)
                    begin
                        state_next = ST_END;
                    end
                    else if (!dp_stat.in_zero)
                    begin
                        state_next = ST_CHAR;
                    end
                end
            end
            ST_CHAR:
            begin
                if (dp_stat.slot_free)
                begin
                    if (!can_step)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (dp_stat.t_is_x)
                    begin
                        dp_cmd.emit    = 1'b1;
                        dp_cmd.sel     = EMIT_CHAR;
                        dp_cmd.advance = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (dp_stat.t_is_nine || dp_stat.t_is_a)
                    begin
                        // A character of the wrong class is dropped silently.
                        if ((dp_stat.t_is_nine && dp_stat.ch_digit) ||
                            (dp_stat.t_is_a && dp_stat.ch_alpha))
                        begin
                            dp_cmd.emit    = 1'b1;
                            dp_cmd.sel     = EMIT_CHAR;
                            dp_cmd.advance = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // A literal is emitted; it consumes the character only on a match.
                        dp_cmd.emit    = 1'b1;
                        dp_cmd.sel     = EMIT_TPL;
                        dp_cmd.advance = 1'b1;
                        if (dp_stat.ch_eq_t)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_END:
            begin
                if (dp_stat.slot_free)
                begin
                    if (can_step && !dp_stat.t_is_x && !dp_stat.t_is_nine && !dp_stat.t_is_a)
                    begin
                        dp_cmd.emit    = 1'b1;
                        dp_cmd.sel     = EMIT_TPL;
                        dp_cmd.advance = 1'b1;
                    end
                    else
                    begin
                        dp_cmd.emit  = 1'b1;
                        dp_cmd.sel   = EMIT_TERM;
                        dp_cmd.clear = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/template_input_mask_formatter_top.sv
// Top level of the template input mask formatter.
// Input requests carry either one typed character (cmd 0) or an end-of-string
// marker (cmd 1); result requests carry one formatted character, or the zero
// terminator with last set. Both channels use valid and stall.
// The template and the output capacity are written through the APB-style port;
// the user must write them only while the block is idle; the block does not
// enforce this. Template registers hold 64 bits, the capacity register 16 bits,
// at byte address 8 * index. A character request is taken in the idle state and
// evaluated in the character state, which writes its result register; a run of
// literals is emitted one per template position, and an end request emits each
// trailing literal, then the terminator. The controller steps one template
// position per cycle when the single result register is free; it sets this rate.
// A zero character with cmd 0 is accepted and has no effect.
// When the receiver stalls, the result register holds its request and the
// controller waits; a new input request is refused until the current one ends.
// Reset clears the position, the output count and the result valid flag, sets
// all template words to zero and the capacity to 64.
`include "template_input_mask_formatter_top_defines.svh"

module template_input_mask_formatter_top
    import timf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  in_item_t          item,
    output logic              res_valid,
    input  logic              res_stall,
    output out_item_t         res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  cfg_word_t         pwdata,
    output cfg_word_t         prdata,
    output logic              pready
);

    cfg_t     cfg;
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    assign pready = 1'b1;

    timf_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    timf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .item_stall (item_stall),
        .dp_stat    (dp_stat),
        .dp_cmd     (dp_cmd)
    );

    timf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res)
    );

    `TIMF_ASSERT_NEXT(a_busy_after_request, item_valid && !item_stall && (item.cmd || item.in_char != 8'd0), item_stall, "block did not go busy after a working request")
    `TIMF_ASSERT(a_emit_needs_slot, !dp_cmd.emit || dp_stat.slot_free, "result written while the result register was held")
    `TIMF_ASSERT(a_term_clears, !(dp_cmd.emit && dp_cmd.sel == EMIT_TERM) || dp_cmd.clear, "terminator sent without clearing the position")
    `TIMF_ASSERT(a_term_is_zero, !(res_valid && res.last) || res.out_char == 8'd0, "terminator carries a nonzero character")

endmodule
